@@ rtl/psu_pkg.sv @@
// Shared types and constants for the PNG scanline unfilter core.
// No dependencies; every other file of the block but psu_if refers to this package.
`default_nettype none

package psu_pkg;

    localparam int MAX_ROW_BYTES_DEF   = 8192;
    localparam int MAX_PIXEL_BYTES_DEF = 8;
    localparam int QUEUE_DEPTH         = 4;

    localparam int BPP_WIDTH = 4;
    localparam int ROW_WIDTH = 14;

    localparam logic [BPP_WIDTH-1:0] BPP_RESET = 4'd1;
    localparam logic [ROW_WIDTH-1:0] ROW_RESET = 14'd1;

    typedef enum logic [0:0] {
        REG_BPP = 1'b0,
        REG_ROW = 1'b1
    } t_reg_index;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } t_filter;

    typedef struct packed {
        logic    is_err;
        t_filter filter;
        logic    left_ok;
        logic    first_row;
        logic    row_end;
    } t_ctl;

endpackage

`default_nettype wire

@@ rtl/psu_if.sv @@
// Stream interfaces of the PNG scanline unfilter core: input bytes and results.
// Uses no package.
`default_nettype none

interface psu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       image_start;

    modport source(output valid, data_byte, image_start, input ready);
    modport sink(input valid, data_byte, image_start, output ready);
endinterface

interface psu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;
    logic       row_end;
    logic       bad_filter;

    modport source(output valid, pixel_byte, row_end, bad_filter, input ready);
    modport sink(input valid, pixel_byte, row_end, bad_filter, output ready);
endinterface

`default_nettype wire

@@ rtl/png_scanline_unfilter_core.sv @@
// PNG scanline unfilter core: takes one inflated byte per cycle unless the queue is full and
// returns reconstructed bytes. Sustained rate is one byte per cycle while the output is not
// stalled. A data byte passes through the queue and the line store read stage, after which
// the result register drives the output. The line store is not cleared after reset and needs
// no clearing pass; rows read it only after the previous row wrote it. The user must write
// the registers over the APB port only while idle; the block itself does not enforce this.
// Depends on psu_pkg, psu_if, psu_front, psu_queue and psu_back.
`default_nettype none

module png_scanline_unfilter_core #(
    parameter int MAX_ROW_BYTES   = psu_pkg::MAX_ROW_BYTES_DEF,
    parameter int MAX_PIXEL_BYTES = psu_pkg::MAX_PIXEL_BYTES_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [2:0]   paddr,
    input  wire [31:0]  pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    psu_in_if.sink      i_in,
    psu_out_if.source   o_out
);

    localparam int CW = $clog2(MAX_ROW_BYTES);
    localparam int SW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int QW = $bits(psu_pkg::t_ctl) + 8 + CW + SW;

    logic [psu_pkg::BPP_WIDTH-1:0] r_bpp;
    logic [psu_pkg::ROW_WIDTH-1:0] r_row;
    psu_pkg::t_reg_index           reg_sel;

    logic          push;
    psu_pkg::t_ctl push_ctl;
    logic [7:0]    push_byte;
    logic [CW-1:0] push_col;
    logic [SW-1:0] push_slot;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;
    logic [QW-1:0] q_data;

    assign pready  = 1'b1;
    assign reg_sel = psu_pkg::t_reg_index'(paddr[2]);

    always_comb begin
        unique case (reg_sel)
            psu_pkg::REG_BPP: prdata = 32'(r_bpp);
            psu_pkg::REG_ROW: prdata = 32'(r_row);
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp <= psu_pkg::BPP_RESET;
            r_row <= psu_pkg::ROW_RESET;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_sel)
                psu_pkg::REG_BPP: r_bpp <= pwdata[psu_pkg::BPP_WIDTH-1:0];
                psu_pkg::REG_ROW: r_row <= pwdata[psu_pkg::ROW_WIDTH-1:0];
                default:          r_bpp <= r_bpp;
            endcase
        end
    end

    psu_front #(
        .MAX_ROW_BYTES   (MAX_ROW_BYTES),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_bpp       (r_bpp),
        .i_row_bytes (r_row),
        .i_full      (q_full),
        .o_push      (push),
        .o_ctl       (push_ctl),
        .o_byte      (push_byte),
        .o_col       (push_col),
        .o_slot      (push_slot)
    );

    psu_queue #(
        .WIDTH (QW),
        .DEPTH (psu_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({push_ctl, push_byte, push_col, push_slot}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    psu_back #(
        .MAX_ROW_BYTES   (MAX_ROW_BYTES),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire

@@ rtl/psu_front.sv @@
// Front end: accepts stream bytes, tracks row framing and error halt, and
// queues one work entry per data byte or bad filter type. Depends on psu_pkg, psu_if.
`default_nettype none

module psu_front #(
    parameter int MAX_ROW_BYTES   = psu_pkg::MAX_ROW_BYTES_DEF,
    parameter int MAX_PIXEL_BYTES = psu_pkg::MAX_PIXEL_BYTES_DEF,
    localparam int CW = $clog2(MAX_ROW_BYTES),
    localparam int SW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    psu_in_if.sink                            i_in,
    input  wire [psu_pkg::BPP_WIDTH-1:0]      i_bpp,
    input  wire [psu_pkg::ROW_WIDTH-1:0]      i_row_bytes,
    input  wire                               i_full,
    output logic                              o_push,
    output psu_pkg::t_ctl                     o_ctl,
    output logic [7:0]                        o_byte,
    output logic [CW-1:0]                     o_col,
    output logic [SW-1:0]                     o_slot
);

    localparam int LW = (CW + 1 > psu_pkg::ROW_WIDTH) ? CW + 1 : psu_pkg::ROW_WIDTH;

    logic             r_halted, n_halted;
    logic             r_await, n_await;
    logic             r_first, n_first;
    logic [CW-1:0]    r_col, n_col;
    psu_pkg::t_filter r_filter, n_filter;
    logic [SW-1:0]    r_res [MAX_PIXEL_BYTES];

    logic             clear_res;
    logic             inc_res;
    logic             accept;
    logic             halted_eff;
    logic             await_eff;
    logic             first_eff;
    logic [CW-1:0]    col_eff;
    logic [psu_pkg::BPP_WIDTH-1:0] bpp_eff;
    logic [LW-1:0]    row_eff;
    logic [LW-1:0]    row_ext;
    logic [LW-1:0]    col_next;
    logic             row_done;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;

    always_comb begin
        if (i_bpp == '0) begin
            bpp_eff = psu_pkg::BPP_WIDTH'(1);
        end else if (i_bpp > psu_pkg::BPP_WIDTH'(MAX_PIXEL_BYTES)) begin
            bpp_eff = psu_pkg::BPP_WIDTH'(MAX_PIXEL_BYTES);
        end else begin
            bpp_eff = i_bpp;
        end
        row_ext = LW'(i_row_bytes);
        if (row_ext == '0) begin
            row_eff = LW'(1);
        end else if (row_ext > LW'(MAX_ROW_BYTES)) begin
            row_eff = LW'(MAX_ROW_BYTES);
        end else begin
            row_eff = row_ext;
        end
    end

    always_comb begin
        halted_eff = r_halted && !i_in.image_start;
        await_eff  = r_await || i_in.image_start;
        first_eff  = r_first || i_in.image_start;
        col_eff    = i_in.image_start ? '0 : r_col;
        col_next   = LW'(col_eff) + LW'(1);
        row_done   = col_next >= row_eff;

        n_halted  = r_halted;
        n_await   = r_await;
        n_first   = r_first;
        n_col     = r_col;
        n_filter  = r_filter;
        clear_res = 1'b0;
        inc_res   = 1'b0;

        o_push           = 1'b0;
        o_ctl.is_err     = 1'b0;
        o_ctl.filter     = r_filter;
        o_ctl.left_ok    = col_eff >= CW'(bpp_eff);
        o_ctl.first_row  = first_eff;
        o_ctl.row_end    = row_done;
        o_byte           = i_in.data_byte;
        o_col            = col_eff;
        o_slot           = r_res[SW'(bpp_eff - psu_pkg::BPP_WIDTH'(1))];

        if (accept) begin
            n_halted = halted_eff;
            n_await  = await_eff;
            n_first  = first_eff;
            n_col    = col_eff;
            if (!halted_eff) begin
                if (await_eff) begin
                    if (i_in.data_byte > 8'(psu_pkg::FILT_PAETH)) begin
                        n_halted     = 1'b1;
                        o_push       = 1'b1;
                        o_ctl.is_err = 1'b1;
                        o_ctl.filter = psu_pkg::FILT_NONE;
                    end else begin
                        n_filter  = psu_pkg::t_filter'(i_in.data_byte[2:0]);
                        n_await   = 1'b0;
                        n_col     = '0;
                        clear_res = 1'b1;
                    end
                end else begin
                    o_push = 1'b1;
                    if (row_done) begin
                        n_await   = 1'b1;
                        n_first   = 1'b0;
                        n_col     = '0;
                        clear_res = 1'b1;
                    end else begin
                        n_col   = col_next[CW-1:0];
                        inc_res = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_halted <= 1'b0;
            r_await  <= 1'b1;
            r_first  <= 1'b1;
            r_col    <= '0;
            r_filter <= psu_pkg::FILT_NONE;
        end else begin
            r_halted <= n_halted;
            r_await  <= n_await;
            r_first  <= n_first;
            r_col    <= n_col;
            r_filter <= n_filter;
        end
    end

    // One residue counter per pixel size keeps column modulo each possible width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
                r_res[k] <= '0;
            end
        end else if (clear_res) begin
            for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
                r_res[k] <= '0;
            end
        end else if (inc_res) begin
            for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
                if ((SW + 1)'(r_res[k]) + (SW + 1)'(1) == (SW + 1)'(k + 1)) begin
                    r_res[k] <= '0;
                end else begin
                    r_res[k] <= r_res[k] + SW'(1);
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/psu_queue.sv @@
// Small flop-based FIFO that decouples the front end from the back end.
// Depends on psu_pkg for its default depth.
`default_nettype none

module psu_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = psu_pkg::QUEUE_DEPTH,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int NW = $clog2(DEPTH + 1)
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire [WIDTH-1:0]  i_data,
    output logic             o_full,
    input  wire              i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [NW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = r_count == NW'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + NW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - NW'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/psu_back.sv @@
// Back end: reads the line store, applies the filter predictor, updates the
// pixel histories and line store, and holds the result register. Depends on psu_pkg, psu_if.
`default_nettype none

module psu_back #(
    parameter int MAX_ROW_BYTES   = psu_pkg::MAX_ROW_BYTES_DEF,
    parameter int MAX_PIXEL_BYTES = psu_pkg::MAX_PIXEL_BYTES_DEF,
    localparam int CW = $clog2(MAX_ROW_BYTES),
    localparam int SW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1,
    localparam int QW = $bits(psu_pkg::t_ctl) + 8 + CW + SW
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_q_valid,
    input  wire [QW-1:0]  i_q_data,
    output logic          o_q_pop,
    psu_out_if.source     o_out
);

    logic [7:0]     r_line [MAX_ROW_BYTES];
    logic [7:0]     r_left [MAX_PIXEL_BYTES];
    logic [7:0]     r_upleft [MAX_PIXEL_BYTES];

    psu_pkg::t_ctl  q_ctl;
    logic [7:0]     q_byte;
    logic [CW-1:0]  q_col;
    logic [SW-1:0]  q_slot;

    logic           r_s1_valid;
    psu_pkg::t_ctl  r_s1_ctl;
    logic [7:0]     r_s1_byte;
    logic [CW-1:0]  r_s1_col;
    logic [SW-1:0]  r_s1_slot;
    logic [7:0]     r_rd_data;
    logic           r_byp;
    logic [7:0]     r_byp_data;

    logic           r_out_valid;
    logic [7:0]     r_out_pixel;
    logic           r_out_row_end;
    logic           r_out_bad;

    logic           s1_adv;
    logic           wr_en;
    logic [7:0]     above;
    logic [7:0]     left;
    logic [7:0]     upleft;
    logic [7:0]     pred;
    logic [7:0]     recon;
    logic [7:0]     pa;
    logic [7:0]     pb;
    logic [8:0]     pc;
    logic [8:0]     sum_ab;
    logic [8:0]     twice_c;

    assign {q_ctl, q_byte, q_col, q_slot} = i_q_data;

    assign s1_adv  = r_s1_valid && (!r_out_valid || o_out.ready);
    assign o_q_pop = i_q_valid && (!r_s1_valid || s1_adv);
    assign wr_en   = s1_adv && !r_s1_ctl.is_err;

    always_comb begin
        above   = r_s1_ctl.first_row ? 8'd0 : (r_byp ? r_byp_data : r_rd_data);
        left    = r_s1_ctl.left_ok ? r_left[r_s1_slot] : 8'd0;
        upleft  = (r_s1_ctl.left_ok && !r_s1_ctl.first_row) ? r_upleft[r_s1_slot] : 8'd0;
        pa      = (above > upleft) ? above - upleft : upleft - above;
        pb      = (left > upleft) ? left - upleft : upleft - left;
        sum_ab  = 9'(left) + 9'(above);
        twice_c = {upleft, 1'b0};
        pc      = (sum_ab > twice_c) ? sum_ab - twice_c : twice_c - sum_ab;
        unique case (r_s1_ctl.filter)
            psu_pkg::FILT_NONE:  pred = 8'd0;
            psu_pkg::FILT_SUB:   pred = left;
            psu_pkg::FILT_UP:    pred = above;
            psu_pkg::FILT_AVG:   pred = sum_ab[8:1];
            psu_pkg::FILT_PAETH: begin
                if (9'(pa) <= 9'(pb) && 9'(pa) <= pc) begin
                    pred = left;
                end else if (9'(pb) <= pc) begin
                    pred = above;
                end else begin
                    pred = upleft;
                end
            end
            default:             pred = 8'd0;
        endcase
        recon = r_s1_byte + pred;
    end

    // The read is issued as the entry enters the stage; a write to the same
    // column in that cycle is forwarded instead of the stale word.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_rd_data <= r_line[q_col];
        end
        if (wr_en) begin
            r_line[r_s1_col] <= recon;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s1_ctl   <= q_ctl;
            r_s1_byte  <= q_byte;
            r_s1_col   <= q_col;
            r_s1_slot  <= q_slot;
            r_byp_data <= recon;
        end
        if (s1_adv) begin
            r_out_pixel   <= r_s1_ctl.is_err ? 8'd0 : recon;
            r_out_row_end <= r_s1_ctl.is_err ? 1'b0 : r_s1_ctl.row_end;
            r_out_bad     <= r_s1_ctl.is_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_byp       <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_s1_valid <= 1'b1;
                r_byp      <= wr_en && (r_s1_col == q_col);
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
                r_left[k]   <= 8'd0;
                r_upleft[k] <= 8'd0;
            end
        end else if (wr_en) begin
            r_left[r_s1_slot]   <= recon;
            r_upleft[r_s1_slot] <= above;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.pixel_byte = r_out_pixel;
    assign o_out.row_end    = r_out_row_end;
    assign o_out.bad_filter = r_out_bad;

    a_err_result_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.bad_filter |-> o_out.pixel_byte == 8'd0 && !o_out.row_end)
        else $error("error result carries data");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_adv |=> r_s1_valid && $stable(r_s1_col))
        else $error("stalled entry lost");

    a_bypass_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop && wr_en && r_s1_col == q_col |=> r_byp)
        else $error("line store forwarding missed");

endmodule

`default_nettype wire
